### hw/rtl/assert_macros.svh
// Assertion macros for the LED strip animator RTL.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSMA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lsma_pkg.sv
// Package for the LED strip mode animator: sizes, colour constants, codes,
// controller types and the wave and scaling helpers. No dependencies.
`default_nettype none

package lsma_pkg;

  // Strip geometry and field widths.
  localparam int PIXEL_COUNT = 16;
  localparam int IDX_W       = 6;
  localparam int TIME_W      = 32;
  localparam int IVL_W       = 16;
  localparam int CH_W        = 8;

  localparam logic [IVL_W-1:0] INTERVAL_RESET = 16'd20;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_MODE = 1'b1;

  // Animation modes.
  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_IDLE   = 3'd1,
    MODE_LISTEN = 3'd2,
    MODE_THINK  = 3'd3,
    MODE_SPEAK  = 3'd4,
    MODE_NOTIFY = 3'd5,
    MODE_ERROR  = 3'd6,
    MODE_SLEEP  = 3'd7
  } lsma_mode_t;

  // Scale factors and fixed colours.
  localparam logic [CH_W-1:0] IDLE_F     = 8'd90;
  localparam logic [CH_W-1:0] IDLE_B_F   = 8'd160;
  localparam logic [CH_W-1:0] LISTEN_F   = 8'd120;
  localparam logic [CH_W-1:0] SPEAK_G_F  = 8'd200;
  localparam logic [CH_W-1:0] SPEAK_STEP = 8'd24;
  localparam logic [CH_W-1:0] SPEAK_B    = 8'd30;
  localparam logic [CH_W-1:0] ERROR_F    = 8'd200;
  localparam logic [CH_W-1:0] SLEEP_F    = 8'd24;
  localparam logic [CH_W-1:0] SLEEP_B_F  = 8'd120;
  localparam logic [CH_W-1:0] HEAD_R     = 8'd255;
  localparam logic [CH_W-1:0] HEAD_G     = 8'd140;
  localparam logic [CH_W-1:0] TAIL_R     = 8'd60;
  localparam logic [CH_W-1:0] TAIL_G     = 8'd30;
  localparam logic [CH_W-1:0] NOTIFY_R   = 8'd255;
  localparam logic [CH_W-1:0] NOTIFY_G   = 8'd200;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_LEVEL1,
    ST_LEVEL2,
    ST_EMIT
  } lsma_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic apply_mode;
    logic start_frame;
    logic calc_l1;
    logic calc_l2;
    logic emit;
  } lsma_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_mode;
    logic frame_due;
    logic out_free;
    logic last_pixel;
  } lsma_sts_t;

  // Triangle wave: rises by two per step up to 254, then falls back.
  function automatic logic [CH_W-1:0] tri_wave(input logic [CH_W-1:0] p);
    logic [CH_W-1:0] r;
    if (p[CH_W-1]) begin
      r = {~p[CH_W-2:0], 1'b0};
    end else begin
      r = {p[CH_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // v * f / 255 rounded down; exact for any 16-bit product.
  function automatic logic [CH_W-1:0] scale255(input logic [CH_W-1:0] v,
                                               input logic [CH_W-1:0] f);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = {8'd0, v} * {8'd0, f};
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // Head pixel of the chase: (phase / 8) mod PIXEL_COUNT, as a small table.
  function automatic logic [IDX_W-1:0] head_of(input logic [CH_W-1:0] p);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      if (p[CH_W-1:3] == 5'(k)) begin
        r = IDX_W'(k % PIXEL_COUNT);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lsma_if.sv
// Channel interfaces of the LED strip mode animator: command items in,
// pixel colours out. Depends on lsma_pkg for the field widths.
`default_nettype none

interface lsma_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [lsma_pkg::TIME_W-1:0]    now_ms;
  logic [2:0]                     mode;

  modport source (output valid, output kind, output now_ms, output mode, input ready);
  modport sink   (input valid, input kind, input now_ms, input mode, output ready);
endinterface

interface lsma_pix_if;
  logic                           valid;
  logic                           ready;
  logic [lsma_pkg::IDX_W-1:0]     pixel_index;
  logic [lsma_pkg::CH_W-1:0]      red;
  logic [lsma_pkg::CH_W-1:0]      green;
  logic [lsma_pkg::CH_W-1:0]      blue;
  logic                           last;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/led_strip_mode_animator_core.sv
// Top level of the LED strip mode animator: joins controller and datapath.
// Depends on lsma_pkg, lsma_if, lsma_ctrl, lsma_datapath, assert_macros.svh.
//
//   Channel  Dir  Handshake            Payload
//   cmd      in   valid/ready          kind, now_ms, mode
//   pix      out  valid/ready          pixel_index, red, green, blue, last
//   cfg      in   cfg_we (no stall)    cfg_wdata = frame interval in ms
//
// A mode item or a tick that renders nothing passes the accept and decide states.
// A rendered frame passes accept, decide, two level-scaling steps, then one
// pixel per cycle from the output register while the output does not stall.
// Output stalls hold the pixel sequencer; the next item is taken while the
// final pixel still waits. Reset is synchronous, active high.
`default_nettype none

`include "assert_macros.svh"

module led_strip_mode_animator_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [lsma_pkg::IVL_W-1:0]   cfg_wdata,
  lsma_cmd_if.sink                     cmd,
  lsma_pix_if.source                   pix
);
  import lsma_pkg::*;

  lsma_ctl_t ctl;
  lsma_sts_t sts;
  logic      in_ready;

  assign cmd.ready = in_ready;

  // Sequencer.
  lsma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  // State, scaling and output register.
  lsma_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_kind     (cmd.kind),
    .in_now_ms   (cmd.now_ms),
    .in_mode     (cmd.mode),
    .out_ready   (pix.ready),
    .out_valid   (pix.valid),
    .pixel_index (pix.pixel_index),
    .red         (pix.red),
    .green       (pix.green),
    .blue        (pix.blue),
    .last        (pix.last)
  );

  // A pixel is never loaded over one that has not been taken.
  `LSMA_ASSERT_IMPL(a_emit_free, ctl.emit, !pix.valid || pix.ready, "pixel overwritten")
  // A started frame always goes on to level scaling.
  `LSMA_ASSERT_NEXT(a_frame_seq, ctl.start_frame, ctl.calc_l1, "frame sequence broken")
  // Once the final pixel is loaded, the block takes items again.
  `LSMA_ASSERT_NEXT(a_end_ready, ctl.emit && sts.last_pixel, cmd.ready, "not ready after frame")

endmodule

`default_nettype wire

### hw/rtl/lsma_ctrl.sv
// Controller of the LED strip mode animator: sequences item decode, level
// precompute and pixel emission. Depends on lsma_pkg.
`default_nettype none

module lsma_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output lsma_pkg::lsma_ctl_t   ctl,
  input  lsma_pkg::lsma_sts_t   sts
);
  import lsma_pkg::*;

  lsma_state_t state;
  lsma_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts.is_mode && sts.frame_due) begin
          state_next = ST_LEVEL1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LEVEL1: state_next = ST_LEVEL2;
      ST_LEVEL2: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free && sts.last_pixel) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
      end
      ST_DECIDE: begin
        ctl.apply_mode  = sts.is_mode;
        ctl.start_frame = !sts.is_mode && sts.frame_due;
      end
      ST_LEVEL1: ctl.calc_l1 = 1'b1;
      ST_LEVEL2: ctl.calc_l2 = 1'b1;
      ST_EMIT:   ctl.emit    = sts.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/lsma_datapath.sv
// Datapath of the LED strip mode animator: animation state, frame timing,
// level scaling and the pixel output register. Depends on lsma_pkg.
`default_nettype none

module lsma_datapath (
  input  wire                           clk,
  input  wire                           rst,
  input  lsma_pkg::lsma_ctl_t           ctl,
  output lsma_pkg::lsma_sts_t           sts,
  input  wire                           cfg_we,
  input  wire  [lsma_pkg::IVL_W-1:0]    cfg_wdata,
  input  wire                           in_kind,
  input  wire  [lsma_pkg::TIME_W-1:0]   in_now_ms,
  input  wire  [2:0]                    in_mode,
  input  wire                           out_ready,
  output logic                          out_valid,
  output logic [lsma_pkg::IDX_W-1:0]    pixel_index,
  output logic [lsma_pkg::CH_W-1:0]     red,
  output logic [lsma_pkg::CH_W-1:0]     green,
  output logic [lsma_pkg::CH_W-1:0]     blue,
  output logic                          last
);
  import lsma_pkg::*;

  // Architectural state and configuration.
  logic [IVL_W-1:0]  frame_interval;
  lsma_mode_t        cur_mode;
  logic [CH_W-1:0]   phase;
  logic [TIME_W-1:0] last_time;

  // Latched item.
  logic              item_kind;
  logic [TIME_W-1:0] item_now;
  logic [2:0]        item_mode;

  // Per-frame precomputed values.
  logic [CH_W-1:0]   tri_r;
  logic [CH_W-1:0]   lvl1;
  logic [CH_W-1:0]   lvl2;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CH_W-1:0]   wave_arg;
  logic [IDX_W-1:0]  pix_cnt;

  logic [TIME_W-1:0] elapsed;
  logic [CH_W-1:0]   l1_arg;
  logic [CH_W-1:0]   l1_fac;
  logic [CH_W-1:0]   l2_fac;
  logic [CH_W-1:0]   l1_tri;
  logic [IDX_W-1:0]  head_next;
  logic [CH_W-1:0]   wave_tri;
  logic [CH_W-1:0]   r_next;
  logic [CH_W-1:0]   g_next;
  logic [CH_W-1:0]   b_next;

  // Status toward the controller.
  assign elapsed        = item_now - last_time;
  assign sts.is_mode    = (item_kind == KIND_MODE);
  assign sts.frame_due  = (elapsed >= {{(TIME_W-IVL_W){1'b0}}, frame_interval});
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.last_pixel = (pix_cnt == IDX_W'(PIXEL_COUNT - 1));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      frame_interval <= cfg_wdata;
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item_kind <= in_kind;
      item_now  <= in_now_ms;
      item_mode <= in_mode;
    end
  end

  // Mode, phase and frame time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode  <= MODE_OFF;
      phase     <= '0;
      last_time <= '0;
    end else if (ctl.apply_mode) begin
      if (item_mode != cur_mode) begin
        cur_mode <= lsma_mode_t'(item_mode);
        phase    <= '0;
      end
    end else if (ctl.start_frame) begin
      last_time <= item_now;
      phase     <= phase + 8'd1;
    end
  end

  // Wave argument and factors of the first and second scaling steps.
  always_comb begin
    l1_arg = phase;
    l1_fac = '0;
    l2_fac = '0;
    case (cur_mode)
      MODE_IDLE: begin
        l1_fac = IDLE_F;
        l2_fac = IDLE_B_F;
      end
      MODE_LISTEN: begin
        l1_arg = phase + {phase[CH_W-2:0], 1'b0};
        l1_fac = LISTEN_F;
      end
      MODE_ERROR: begin
        l1_arg = {phase[CH_W-2:0], 1'b0};
        l1_fac = ERROR_F;
      end
      MODE_SLEEP: begin
        l1_fac = SLEEP_F;
        l2_fac = SLEEP_B_F;
      end
      default: begin
        l1_fac = '0;
      end
    endcase
  end

  assign l1_tri    = tri_wave(l1_arg);
  assign head_next = head_of(phase);

  // Per-frame level registers.
  always_ff @(posedge clk) begin
    if (ctl.calc_l1) begin
      tri_r    <= l1_tri;
      lvl1     <= scale255(l1_tri, l1_fac);
      head     <= head_next;
      tail     <= (head_next == '0) ? IDX_W'(PIXEL_COUNT - 1) : head_next - 6'd1;
      wave_arg <= {phase[CH_W-2:0], 1'b0};
      pix_cnt  <= '0;
    end else if (ctl.emit) begin
      wave_arg <= wave_arg + SPEAK_STEP;
      pix_cnt  <= pix_cnt + 6'd1;
    end
    if (ctl.calc_l2) begin
      lvl2 <= scale255(lvl1, l2_fac);
    end
  end

  assign wave_tri = tri_wave(wave_arg);

  // Colour of the current pixel.
  always_comb begin
    r_next = '0;
    g_next = '0;
    b_next = '0;
    case (cur_mode)
      MODE_IDLE: begin
        g_next = lvl1;
        b_next = lvl2;
      end
      MODE_LISTEN: begin
        g_next = lvl1;
        b_next = tri_r;
      end
      MODE_THINK: begin
        // The tail wins when head and tail coincide on a one-pixel strip.
        if (pix_cnt == tail) begin
          r_next = TAIL_R;
          g_next = TAIL_G;
        end else if (pix_cnt == head) begin
          r_next = HEAD_R;
          g_next = HEAD_G;
        end
      end
      MODE_SPEAK: begin
        r_next = wave_tri;
        g_next = scale255(wave_tri, SPEAK_G_F);
        b_next = SPEAK_B;
      end
      MODE_NOTIFY: begin
        if (!phase[5]) begin
          r_next = NOTIFY_R;
          g_next = NOTIFY_G;
        end
      end
      MODE_ERROR: begin
        r_next = lvl1;
      end
      MODE_SLEEP: begin
        r_next = lvl1;
        b_next = lvl2;
      end
      default: begin
        r_next = '0;
      end
    endcase
  end

  // Output register: loads a pixel when empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pixel_index <= pix_cnt;
      red         <= r_next;
      green       <= g_next;
      blue        <= b_next;
      last        <= sts.last_pixel;
    end
  end

endmodule

`default_nettype wire
